@@ sv/bpe_pkg.sv @@
// ----------------------------------------------------------------------------
// bpe_pkg: shared types and codes for the BMP pixel encoder
// Holds the pixel transaction structs, the stage control struct and the
// configuration register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package bpe_pkg;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 13;

    localparam logic [CFG_IDX_W-1:0] CFG_REVERSE_ORDER   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COMPONENTS      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_PLACEMENT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_WIDTH       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PAD_BYTES       = 3'd4;

    localparam logic [1:0] PLACE_NONE     = 2'd0;
    localparam logic [1:0] PLACE_LEADING  = 2'd1;
    localparam logic [1:0] PLACE_TRAILING = 2'd2;
    localparam logic [1:0] PLACE_RSVD     = 2'd3;

    localparam logic [2:0] COMP_GRAY  = 3'd1;
    localparam logic [2:0] COMP_GRAYA = 3'd2;
    localparam logic [2:0] COMP_RGB   = 3'd3;
    localparam logic [2:0] COMP_RGBA  = 3'd4;

    localparam logic [2:0] COUNT_NO_ALPHA = 3'd3;
    localparam logic [2:0] COUNT_ALPHA    = 3'd4;

    localparam logic [7:0] BG_FULL = 8'd255;

    typedef struct packed {
        logic [7:0] chan0;
        logic [7:0] chan1;
        logic [7:0] chan2;
        logic [7:0] chan3;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out0;
        logic [7:0] out1;
        logic [7:0] out2;
        logic [7:0] out3;
        logic [2:0] byte_count;
        logic       row_end;
        logic [1:0] pad_count;
    } t_out_item;

    // Per-pixel decode that travels beside the lanes to the merge stage.
    typedef struct packed {
        logic       reverse;
        logic       gray;
        logic       blend;
        logic [1:0] place;
        logic [7:0] alpha;
        logic       row_end;
        logic [1:0] pad_count;
    } t_ctrl;

endpackage

`default_nettype wire

@@ sv/bmp_pixel_encoder.sv @@
// ----------------------------------------------------------------------------
// bmp_pixel_encoder: BMP scanline byte encoder with alpha composite
// An accepted pixel is registered in the blend lanes, then in the merge output.
// Throughput is one pixel per cycle unless the output holds it off; three blend
// lanes share the pixel and each holds one 8x8 multiply in the first stage.
// Reset is synchronous, active low: it empties the pipeline, clears the
// column counter and loads the register defaults (BGR, RGBA, width 1).
// ----------------------------------------------------------------------------
`default_nettype none

module bmp_pixel_encoder #(
    parameter int MAX_WIDTH = 4096
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_in_valid,
    output logic                                    o_in_ready,
    input  wire bpe_pkg::t_in_item                  i_in_data,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_ready,
    output bpe_pkg::t_out_item                      o_out_data,
    input  wire logic                               i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  wire logic [bpe_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [bpe_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import bpe_pkg::*;

    localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int CMP_W = (COL_W + 1 > CFG_DATA_W) ? COL_W + 1 : CFG_DATA_W;

    // Configuration registers.
    logic                  r_reverse;
    logic [2:0]            r_components;
    logic [1:0]            r_place;
    logic [CFG_DATA_W-1:0] r_row_width;
    logic [1:0]            r_pad_bytes;

    logic [COL_W-1:0] r_col;
    logic [COL_W-1:0] n_col;
    logic             r_s1_valid;
    logic             r_out_valid;
    t_ctrl            r_ctrl;
    t_ctrl            n_ctrl;

    logic             in_fire;
    logic             s2_load;
    logic [2:0]       comp_n;
    logic [1:0]       place_n;
    logic [CMP_W-1:0] width_raw;
    logic [CMP_W-1:0] width_eff;
    logic             row_end_now;

    logic [2:0][7:0]  lane_chan;
    logic [2:0]       lane_bg;
    logic [2:0][7:0]  lane_raw;
    logic [2:0][7:0]  lane_blend;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reverse    <= 1'b1;
            r_components <= COMP_RGBA;
            r_place      <= PLACE_NONE;
            r_row_width  <= CFG_DATA_W'(1);
            r_pad_bytes  <= 2'd0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_REVERSE_ORDER:   r_reverse    <= i_cfg_data[0];
                CFG_COMPONENTS:      r_components <= i_cfg_data[2:0];
                CFG_ALPHA_PLACEMENT: r_place      <= i_cfg_data[1:0];
                CFG_ROW_WIDTH:       r_row_width  <= i_cfg_data;
                CFG_PAD_BYTES:       r_pad_bytes  <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    // Handshake: the output register and the lane stage form an elastic pipe.
    assign s2_load    = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || s2_load;
    assign in_fire    = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_fire) begin
                r_s1_valid <= 1'b1;
            end else if (s2_load) begin
                r_s1_valid <= 1'b0;
            end
            if (s2_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Decode of the register settings, with out-of-range codes folded in.
    always_comb begin
        comp_n = r_components;
        if (r_components == 3'd0) begin
            comp_n = COMP_GRAY;
        end else if (r_components > COMP_RGBA) begin
            comp_n = COMP_RGBA;
        end
        place_n = (r_place == PLACE_RSVD) ? PLACE_NONE : r_place;

        width_raw = CMP_W'(r_row_width);
        width_eff = width_raw;
        if (width_raw == '0) begin
            width_eff = CMP_W'(1);
        end else if (width_raw > CMP_W'(MAX_WIDTH)) begin
            width_eff = CMP_W'(MAX_WIDTH);
        end
        row_end_now = (CMP_W'(r_col) + CMP_W'(1)) >= width_eff;
        n_col       = row_end_now ? '0 : r_col + COL_W'(1);

        n_ctrl.reverse   = r_reverse;
        n_ctrl.gray      = (comp_n == COMP_GRAY) || (comp_n == COMP_GRAYA);
        n_ctrl.blend     = (comp_n == COMP_RGBA) && (place_n == PLACE_NONE);
        n_ctrl.place     = place_n;
        n_ctrl.row_end   = row_end_now;
        n_ctrl.pad_count = row_end_now ? r_pad_bytes : 2'd0;
        case (comp_n)
            COMP_GRAY:  n_ctrl.alpha = i_in_data.chan0;
            COMP_GRAYA: n_ctrl.alpha = i_in_data.chan1;
            COMP_RGB:   n_ctrl.alpha = i_in_data.chan2;
            default:    n_ctrl.alpha = i_in_data.chan3;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
        end else if (in_fire) begin
            r_col <= n_col;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_ctrl <= n_ctrl;
        end
    end

    // Red and blue blend toward 255, green toward 0.
    assign lane_chan = {i_in_data.chan2, i_in_data.chan1, i_in_data.chan0};
    assign lane_bg   = 3'b101;

    for (genvar g = 0; g < 3; g++) begin : g_lane
        bpe_blend_lane u_lane (
            .i_clk     (i_clk),
            .i_en      (in_fire),
            .i_chan    (lane_chan[g]),
            .i_alpha   (i_in_data.chan3),
            .i_bg_full (lane_bg[g]),
            .o_raw     (lane_raw[g]),
            .o_blend   (lane_blend[g])
        );
    end

    bpe_merge u_merge (
        .i_clk   (i_clk),
        .i_load  (s2_load),
        .i_ctrl  (r_ctrl),
        .i_raw   (lane_raw),
        .i_blend (lane_blend),
        .o_item  (o_out_data)
    );

    assign o_out_valid = r_out_valid;

    a_pad_only_at_row_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.pad_count == 2'd0 || o_out_data.row_end))
        else $error("pad bytes reported away from row end");

    a_count_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.byte_count == COUNT_NO_ALPHA ||
                         o_out_data.byte_count == COUNT_ALPHA))
        else $error("illegal byte count");

    a_no_alpha_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.byte_count == COUNT_NO_ALPHA) |->
            (o_out_data.out3 == 8'd0))
        else $error("fourth byte not zero without alpha");

    a_col_wraps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && row_end_now) |=> (r_col == '0))
        else $error("column counter did not wrap at row end");

    a_col_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CMP_W'(r_col) < CMP_W'(MAX_WIDTH))
        else $error("column counter beyond maximum width");

endmodule

`default_nettype wire

@@ sv/bpe_blend_lane.sv @@
// ----------------------------------------------------------------------------
// bpe_blend_lane: one color channel of the alpha composite
// Registers the raw channel and |c - bg| * alpha, then divides the product
// by 255 and moves it back toward the background value.
// ----------------------------------------------------------------------------
`default_nettype none

module bpe_blend_lane (
    input  wire logic       i_clk,
    input  wire logic       i_en,
    input  wire logic [7:0] i_chan,
    input  wire logic [7:0] i_alpha,
    input  wire logic       i_bg_full,
    output logic      [7:0] o_raw,
    output logic      [7:0] o_blend
);
    import bpe_pkg::*;

    logic [7:0]  n_diff;
    logic [15:0] r_prod;
    logic [7:0]  r_raw;
    logic        r_bg_full;
    logic [16:0] n_sum;
    logic [7:0]  n_quot;

    // Against a full background the channel can only reach it from below.
    assign n_diff = i_bg_full ? (BG_FULL - i_chan) : i_chan;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod    <= 16'(n_diff * i_alpha);
            r_raw     <= i_chan;
            r_bg_full <= i_bg_full;
        end
    end

    // Exact x / 255 for any product of two bytes.
    assign n_sum  = {1'b0, r_prod} + 17'(r_prod[15:8]) + 17'd1;
    assign n_quot = n_sum[15:8];

    assign o_raw   = r_raw;
    assign o_blend = r_bg_full ? (BG_FULL - n_quot) : n_quot;

endmodule

`default_nettype wire

@@ sv/bpe_merge.sv @@
// ----------------------------------------------------------------------------
// bpe_merge: assembles the output bytes of one pixel
// Chooses gray, raw or blended colors, applies channel reversal and places
// the alpha byte, then registers the result transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module bpe_merge (
    input  wire logic               i_clk,
    input  wire logic               i_load,
    input  wire bpe_pkg::t_ctrl     i_ctrl,
    input  wire logic [2:0][7:0]    i_raw,
    input  wire logic [2:0][7:0]    i_blend,
    output bpe_pkg::t_out_item      o_item
);
    import bpe_pkg::*;

    logic [2:0][7:0] n_col;
    logic [7:0]      n_first;
    logic [7:0]      n_last;
    t_out_item       n_item;
    t_out_item       r_item;

    always_comb begin
        n_col   = i_ctrl.blend ? i_blend : i_raw;
        n_first = n_col[0];
        n_last  = n_col[2];
        if (i_ctrl.gray) begin
            n_first  = i_raw[0];
            n_col[1] = i_raw[0];
            n_last   = i_raw[0];
        end else if (i_ctrl.reverse) begin
            n_first = n_col[2];
            n_last  = n_col[0];
        end

        n_item.row_end   = i_ctrl.row_end;
        n_item.pad_count = i_ctrl.pad_count;
        case (i_ctrl.place)
            PLACE_LEADING: begin
                n_item.out0       = i_ctrl.alpha;
                n_item.out1       = n_first;
                n_item.out2       = n_col[1];
                n_item.out3       = n_last;
                n_item.byte_count = COUNT_ALPHA;
            end
            PLACE_TRAILING: begin
                n_item.out0       = n_first;
                n_item.out1       = n_col[1];
                n_item.out2       = n_last;
                n_item.out3       = i_ctrl.alpha;
                n_item.byte_count = COUNT_ALPHA;
            end
            default: begin
                n_item.out0       = n_first;
                n_item.out1       = n_col[1];
                n_item.out2       = n_last;
                n_item.out3       = 8'd0;
                n_item.byte_count = COUNT_NO_ALPHA;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_item <= n_item;
        end
    end

    assign o_item = r_item;

endmodule

`default_nettype wire

@@ tb/bmp_pixel_encoder_test.sv @@
// ----------------------------------------------------------------------------
// bmp_pixel_encoder_test: self-checking bench for the BMP pixel encoder
// Streams pixels through the encoder under random handshake gaps and many
// register settings. Each pixel's scanline bytes, byte count, row end flag
// and pad count are predicted on acceptance and checked in order.
// ----------------------------------------------------------------------------
`default_nettype none

module bmp_pixel_encoder_test;

    timeunit 1ns;
    timeprecision 1ps;

    import bpe_pkg::*;

    localparam real CLK_PERIOD = 10.0;
    localparam int  ROW_LIMIT = 4096;
    localparam int  CYCLE_LIMIT = 500_000;
    localparam int  HOLD_CYCLES = 200;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    t_in_item              i_in_data = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    t_out_item             o_out_data;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    bmp_pixel_encoder #(
        .MAX_WIDTH(ROW_LIMIT)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Shadow copy of the encoder's registers and column counter.
    logic            cfg_reverse = 1'b1;
    logic [2:0]      cfg_components = COMP_RGBA;
    logic [1:0]      cfg_place = PLACE_NONE;
    logic [12:0]     cfg_row_width = 13'd1;
    logic [1:0]      cfg_pad = 2'd0;
    logic [11:0]     column_pos = '0;

    t_in_item        pixels_to_send[$];
    t_out_item       expected_entries[$];

    logic            calm = 1'b0;
    int              send_gap = 0;
    int              recv_gap = 0;
    int              hold_requests = 0;
    int              holds_served = 0;
    int              hold_left = 0;
    int              fail_count = 0;
    int              pixels_checked = 0;
    int              blended_pixels = 0;
    int              row_ends = 0;
    int              settings_used = 0;
    int              cycle_count = 0;

    function automatic logic [7:0] composite(input int c, input int bg, input int a);
        if (c >= bg) begin
            return 8'(bg + ((c - bg) * a) / 255);
        end
        return 8'(bg - ((bg - c) * a) / 255);
    endfunction

    // Predicts the scanline entry for one pixel and advances the column.
    function automatic t_out_item encode_pixel(input t_in_item px);
        t_out_item  res;
        logic [7:0] ch[4];
        logic [7:0] col[3];
        logic [7:0] alpha;
        logic [7:0] swap;
        logic [1:0] place;
        int         comp;
        int         eff_width;
        logic       at_end;
        ch[0] = px.chan0;
        ch[1] = px.chan1;
        ch[2] = px.chan2;
        ch[3] = px.chan3;
        comp = cfg_components;
        if (comp == 0) begin
            comp = COMP_GRAY;
        end
        if (comp > COMP_RGBA) begin
            comp = COMP_RGBA;
        end
        place = (cfg_place == PLACE_RSVD) ? PLACE_NONE : cfg_place;
        eff_width = cfg_row_width;
        if (eff_width == 0) begin
            eff_width = 1;
        end
        if (eff_width > ROW_LIMIT) begin
            eff_width = ROW_LIMIT;
        end
        alpha = ch[comp - 1];

        if (comp <= COMP_GRAYA) begin
            col[0] = ch[0];
            col[1] = ch[0];
            col[2] = ch[0];
        end else begin
            if (comp == COMP_RGBA && place == PLACE_NONE) begin
                col[0] = composite(ch[0], BG_FULL, ch[3]);
                col[1] = composite(ch[1], 0, ch[3]);
                col[2] = composite(ch[2], BG_FULL, ch[3]);
                blended_pixels++;
            end else begin
                col[0] = ch[0];
                col[1] = ch[1];
                col[2] = ch[2];
            end
            if (cfg_reverse) begin
                swap = col[0];
                col[0] = col[2];
                col[2] = swap;
            end
        end

        res = '0;
        if (place == PLACE_LEADING) begin
            res.out0 = alpha;
            res.out1 = col[0];
            res.out2 = col[1];
            res.out3 = col[2];
            res.byte_count = COUNT_ALPHA;
        end else begin
            res.out0 = col[0];
            res.out1 = col[1];
            res.out2 = col[2];
            res.out3 = (place == PLACE_TRAILING) ? alpha : 8'd0;
            res.byte_count = (place == PLACE_TRAILING) ? COUNT_ALPHA : COUNT_NO_ALPHA;
        end

        at_end = (int'(column_pos) + 1 >= eff_width);
        res.row_end = at_end;
        res.pad_count = at_end ? cfg_pad : 2'd0;
        column_pos = at_end ? 12'd0 : column_pos + 12'd1;
        if (at_end) begin
            row_ends++;
        end
        return res;
    endfunction

    function automatic void check_field(input string field, input logic [7:0] got,
                                        input logic [7:0] want);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, got %0d", field, want, got);
            fail_count++;
        end
    endfunction

    // Pixel driver: predicts each accepted transaction, then offers the next.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                expected_entries.push_back(encode_pixel(i_in_data));
            end
            if (!i_in_valid || o_in_ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    i_in_valid <= 1'b0;
                end else if (pixels_to_send.size() > 0) begin
                    i_in_valid <= 1'b1;
                    i_in_data <= pixels_to_send.pop_front();
                    if (!calm && $urandom_range(0, 9) == 0) begin
                        send_gap = $urandom_range(1, 7);
                    end
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor and output backpressure.
    always @(posedge i_clk) begin : result_monitor
        t_out_item want;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (expected_entries.size() == 0) begin
                    $error("result transaction with no pixel outstanding: %h", o_out_data);
                    fail_count++;
                end else begin
                    want = expected_entries.pop_front();
                    check_field("out0", o_out_data.out0, want.out0);
                    check_field("out1", o_out_data.out1, want.out1);
                    check_field("out2", o_out_data.out2, want.out2);
                    check_field("out3", o_out_data.out3, want.out3);
                    check_field("byte_count", 8'(o_out_data.byte_count), 8'(want.byte_count));
                    check_field("row_end", 8'(o_out_data.row_end), 8'(want.row_end));
                    check_field("pad_count", 8'(o_out_data.pad_count), 8'(want.pad_count));
                    pixels_checked++;
                end
            end
            if (hold_requests != holds_served) begin
                holds_served++;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap--;
                i_out_ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 9) == 0) begin
                recv_gap = $urandom_range(1, 7) - 1;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_entries.size());
            $display("** bmp_pixel_encoder: FAILED **");
            $finish;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_REVERSE_ORDER:   cfg_reverse = value[0];
            CFG_COMPONENTS:      cfg_components = value[2:0];
            CFG_ALPHA_PLACEMENT: cfg_place = value[1:0];
            CFG_ROW_WIDTH:       cfg_row_width = value[12:0];
            CFG_PAD_BYTES:       cfg_pad = value[1:0];
            default: ;
        endcase
    endtask

    // Writes every register; noisy settings put junk above each narrow field.
    task automatic set_mode(input logic rev, input logic [2:0] comp, input logic [1:0] place,
                            input logic [12:0] width, input logic [1:0] pad,
                            input logic noisy);
        logic [12:0] junk;
        junk = noisy ? 13'($urandom) : 13'd0;
        write_reg(CFG_REVERSE_ORDER, {junk[12:1], rev});
        write_reg(CFG_COMPONENTS, {junk[12:3], comp});
        write_reg(CFG_ALPHA_PLACEMENT, {junk[12:2], place});
        write_reg(CFG_ROW_WIDTH, width);
        write_reg(CFG_PAD_BYTES, {junk[12:2], pad});
        settings_used++;
    endtask

    task automatic push_pixel(input logic [7:0] c0, input logic [7:0] c1,
                              input logic [7:0] c2, input logic [7:0] c3);
        t_in_item px;
        px.chan0 = c0;
        px.chan1 = c1;
        px.chan2 = c2;
        px.chan3 = c3;
        pixels_to_send.push_back(px);
    endtask

    // Random bytes lean toward the ends of the range, where blending saturates.
    function automatic logic [7:0] rand_byte();
        int pick;
        pick = $urandom_range(0, 7);
        if (pick == 0) begin
            return 8'd0;
        end
        if (pick == 1) begin
            return 8'd255;
        end
        return 8'($urandom);
    endfunction

    task automatic queue_random_pixels(input int count);
        @(negedge i_clk);
        repeat (count) begin
            push_pixel(rand_byte(), rand_byte(), rand_byte(), rand_byte());
        end
    endtask

    // Returns once every queued pixel has been sent and every result checked.
    task automatic wait_drain();
        do @(negedge i_clk);
        while (pixels_to_send.size() != 0 || i_in_valid || expected_entries.size() != 0);
    endtask

    initial begin
        logic [12:0] width;
        int          pick;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: BGR with alpha composite onto magenta, one pixel per row.
        @(negedge i_clk);
        push_pixel(8'd0, 8'd0, 8'd0, 8'd0);
        push_pixel(8'd255, 8'd255, 8'd255, 8'd255);
        push_pixel(8'd255, 8'd0, 8'd255, 8'd128);
        push_pixel(8'd0, 8'd255, 8'd0, 8'd255);
        push_pixel(8'd0, 8'd255, 8'd0, 8'd0);
        push_pixel(8'd200, 8'd100, 8'd50, 8'd1);
        push_pixel(8'd1, 8'd254, 8'd128, 8'd254);
        wait_drain();

        // RGB in forward order with a leading alpha taken from the blue byte;
        // a zero row width acts as one.
        set_mode(1'b0, COMP_RGB, PLACE_LEADING, 13'd0, 2'd3, 1'b0);
        @(negedge i_clk);
        push_pixel(8'd10, 8'd20, 8'd30, 8'd40);
        push_pixel(8'd255, 8'd0, 8'd170, 8'd85);
        push_pixel(8'd0, 8'd255, 8'd85, 8'd170);
        wait_drain();

        // Zero components acts as gray, trailing alpha is the gray byte itself.
        set_mode(1'b1, 3'd0, PLACE_TRAILING, 13'd3, 2'd2, 1'b0);
        @(negedge i_clk);
        push_pixel(8'd77, 8'd1, 8'd2, 8'd3);
        push_pixel(8'd255, 8'd0, 8'd0, 8'd0);
        push_pixel(8'd0, 8'd255, 8'd255, 8'd255);
        push_pixel(8'd128, 8'd64, 8'd32, 8'd16);
        wait_drain();

        // Components above four act as RGBA; reserved placement means no alpha byte.
        set_mode(1'b0, 3'd7, PLACE_RSVD, 13'd2, 2'd1, 1'b0);
        @(negedge i_clk);
        push_pixel(8'd12, 8'd240, 8'd99, 8'd200);
        push_pixel(8'd255, 8'd255, 8'd0, 8'd127);
        push_pixel(8'd0, 8'd0, 8'd255, 8'd255);
        wait_drain();

        // Gray plus alpha leading, then RGBA with trailing alpha left unblended.
        set_mode(1'b1, COMP_GRAYA, PLACE_LEADING, 13'd5, 2'd0, 1'b0);
        @(negedge i_clk);
        push_pixel(8'd33, 8'd201, 8'd7, 8'd9);
        push_pixel(8'd255, 8'd0, 8'd255, 8'd0);
        wait_drain();
        set_mode(1'b1, COMP_RGBA, PLACE_TRAILING, 13'd1, 2'd3, 1'b0);
        @(negedge i_clk);
        push_pixel(8'd1, 8'd2, 8'd3, 8'd4);
        push_pixel(8'd250, 8'd5, 8'd128, 8'd66);
        wait_drain();

        // A long stretch at an oversized row width. The output is held off
        // while pixels keep coming, and midway the sender waits for every result.
        set_mode(1'b1, COMP_RGBA, PLACE_NONE, 13'd8191, 2'd2, 1'b0);
        hold_requests++;
        queue_random_pixels(60);
        wait_drain();
        queue_random_pixels(60);
        wait_drain();

        // Row width dropped below the current column ends the row on the next pixel.
        write_reg(CFG_ROW_WIDTH, 13'd3);
        queue_random_pixels(6);
        wait_drain();

        for (int phase = 0; phase < 16; phase++) begin
            pick = $urandom_range(0, 9);
            if (pick == 0) begin
                width = 13'd0;
            end else if (pick == 1) begin
                width = 13'($urandom_range(ROW_LIMIT + 1, 8191));
            end else if (pick == 2) begin
                width = 13'(ROW_LIMIT);
            end else begin
                width = 13'($urandom_range(1, 16));
            end
            if (phase == 13) begin
                calm = 1'b1;
            end
            set_mode(1'($urandom), 3'(phase % 8), 2'((phase + phase / 8) % 4), width,
                     2'($urandom), 1'($urandom));
            queue_random_pixels($urandom_range(60, 140));
            wait_drain();
        end

        repeat (10) @(posedge i_clk);
        if (expected_entries.size() != 0) begin
            $error("%0d expected results never arrived", expected_entries.size());
            fail_count++;
        end
        $display("Checked %0d pixels over %0d register settings (%0d alpha composites).",
                 pixels_checked, settings_used, blended_pixels);
        $display("Saw %0d row ends, including a mid-row cut and widths past the maximum.",
                 row_ends);
        if (fail_count == 0) begin
            $display("** bmp_pixel_encoder: PASSED **");
        end else begin
            $display("** bmp_pixel_encoder: FAILED **");
        end
        $finish;
    end

endmodule

`default_nettype wire
